// File: design/n2d_pkg.sv
// n2d_pkg: shared types and constants for the nfa to dfa subset construction block
// depends on nothing
package n2d_pkg;

   localparam int NFA_STATES = 8;
   localparam int SYMBOLS    = 4;
   localparam int DFA_STATES = 64;

   localparam int NFA_W   = 3;
   localparam int SYM_W   = 2;
   localparam int ID_W    = 6;
   localparam int COUNT_W = 7;
   localparam int NTAB_W  = NFA_W + SYM_W;
   localparam int DTAB_W  = ID_W + SYM_W;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_RUN  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   localparam logic CSR_SYMBOL_COUNT = 1'b0;
   localparam logic CSR_FINAL_MASK   = 1'b1;

   typedef struct packed {
      logic [1:0]       mode;
      logic [NFA_W-1:0] nfa_state;
      logic [SYM_W-1:0] symbol;
      logic [7:0]       target_mask;
      logic [ID_W-1:0]  dfa_state;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] dfa_count;
      logic               overflow;
      logic [ID_W-1:0]    next_state;
      logic               has_next;
      logic               is_final;
      logic [7:0]         subset;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0] next_state;
      logic            has_next;
      logic            is_final;
      logic [7:0]      subset;
   } res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDCAP,
      ST_INIT,
      ST_FETCH,
      ST_CUR,
      ST_UNION,
      ST_SRCH,
      ST_WRITE,
      ST_RESP
   } state_type;

endpackage

// File: design/nfa_to_dfa_subset_construction.sv
// nfa_to_dfa_subset_construction: top level, nfa table, sequencer and subset search
// depends on n2d_pkg and n2d_ram
// load beat: table entry written on accept, then the resp state; read beat: rams captured in rdcap, then resp
// run beat: its length is set by the one-entry-per-cycle union over each subset and symbol
//   and by the serial search through the subset ram
// one beat at a time; a new beat is taken while the previous result waits in the output register
// synchronous reset clears the nfa table, counts and overflow flag, and sets config defaults
module nfa_to_dfa_subset_construction
   import n2d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_index,
   input  logic [7:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [2:0]         symcnt_ff;
   logic [7:0]         fmask_ff;
   logic [7:0]         nfa_ff [NFA_STATES*SYMBOLS];
   req_type            item_ff, item_in;
   res_type            res_ff, res_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] wp_ff, wp_in;
   logic [COUNT_W-1:0] k_ff, k_in;
   logic [ID_W-1:0]    pk_ff, pk_in;
   logic               pend_ff, pend_in;
   logic               ovf_ff, ovf_in;
   logic [NFA_W-1:0]   q_ff, q_in;
   logic [SYM_W-1:0]   s_ff, s_in;
   logic [7:0]         cur_ff, cur_in;
   logic [7:0]         uni_ff, uni_in;
   logic [ID_W:0]      ent_ff, ent_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_fire;
   logic [2:0]         nsym;
   logic [7:0]         uni_step;
   logic               hit;
   logic               load_we;

   logic               sr_we;
   logic [ID_W-1:0]    sr_waddr, sr_raddr;
   logic [8:0]         sr_wdata, sr_rdata;
   logic               dr_we;
   logic [DTAB_W-1:0]  dr_waddr, dr_raddr;
   logic [ID_W:0]      dr_rdata;

   n2d_ram #(.WIDTH(9), .DEPTH(DFA_STATES)) u_subset_ram (
      .clock (clock),
      .we    (sr_we),
      .waddr (sr_waddr),
      .wdata (sr_wdata),
      .raddr (sr_raddr),
      .rdata (sr_rdata)
   );

   n2d_ram #(.WIDTH(ID_W+1), .DEPTH(DFA_STATES*SYMBOLS)) u_dfa_ram (
      .clock (clock),
      .we    (dr_we),
      .waddr (dr_waddr),
      .wdata (ent_ff),
      .raddr (dr_raddr),
      .rdata (dr_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign nsym      = (symcnt_ff > 3'(SYMBOLS)) ? 3'(SYMBOLS) : symcnt_ff;
   assign uni_step  = uni_ff | (cur_ff[q_ff] ? nfa_ff[{q_ff, s_ff}] : 8'h00);
   assign hit       = pend_ff && (sr_rdata[7:0] == uni_ff);
   assign load_we   = req_fire && (req_data.mode == MODE_LOAD);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.mode == MODE_RUN) begin
                  state_in = ST_INIT;
               end else if (req_data.mode == MODE_READ
                            && {1'b0, req_data.dfa_state} < count_ff) begin
                  state_in = ST_RDCAP;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_RDCAP: state_in = ST_RESP;
         ST_INIT:  state_in = ST_FETCH;
         ST_FETCH: state_in = ST_CUR;
         ST_CUR:   state_in = ST_UNION;
         ST_UNION: begin
            if (q_ff == NFA_W'(NFA_STATES-1)) begin
               if ({1'b0, s_ff} >= nsym || uni_step == 8'h00) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_SRCH;
               end
            end
         end
         ST_SRCH: begin
            if (hit || k_ff >= count_ff) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (s_ff == SYM_W'(SYMBOLS-1)) begin
               state_in = (wp_ff + 1'b1 < count_ff) ? ST_FETCH : ST_RESP;
            end else begin
               state_in = ST_UNION;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and ram controls
   always_comb begin
      item_in      = item_ff;
      res_in       = res_ff;
      count_in     = count_ff;
      wp_in        = wp_ff;
      k_in         = k_ff;
      pk_in        = pk_ff;
      pend_in      = pend_ff;
      ovf_in       = ovf_ff;
      q_in         = q_ff;
      s_in         = s_ff;
      cur_in       = cur_ff;
      uni_in       = uni_ff;
      ent_in       = ent_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      sr_we        = 1'b0;
      sr_waddr     = count_ff[ID_W-1:0];
      sr_wdata     = {|(uni_ff & fmask_ff), uni_ff};
      sr_raddr     = k_ff[ID_W-1:0];
      dr_we        = 1'b0;
      dr_waddr     = {wp_ff[ID_W-1:0], s_ff};
      dr_raddr     = {item_ff.dfa_state, item_ff.symbol};
      unique case (state_ff)
         ST_IDLE: begin
            sr_raddr = req_data.dfa_state;
            dr_raddr = {req_data.dfa_state, req_data.symbol};
            if (req_fire) begin
               item_in = req_data;
               res_in  = '0;
            end
         end
         ST_RDCAP: begin
            res_in.is_final   = sr_rdata[8];
            res_in.subset     = sr_rdata[7:0];
            res_in.has_next   = dr_rdata[ID_W];
            res_in.next_state = dr_rdata[ID_W] ? dr_rdata[ID_W-1:0] : '0;
         end
         ST_INIT: begin
            sr_we    = 1'b1;
            sr_waddr = '0;
            sr_wdata = {fmask_ff[0], 8'h01};
            count_in = COUNT_W'(1);
            ovf_in   = 1'b0;
            wp_in    = '0;
         end
         ST_FETCH: begin
            sr_raddr = wp_ff[ID_W-1:0];
            s_in     = '0;
            q_in     = '0;
            uni_in   = '0;
         end
         ST_CUR: begin
            cur_in = sr_rdata[7:0];
         end
         ST_UNION: begin
            q_in    = q_ff + 1'b1;
            uni_in  = uni_step;
            k_in    = '0;
            pend_in = 1'b0;
            ent_in  = '0;
            if (q_ff == NFA_W'(NFA_STATES-1) && {1'b0, s_ff} >= nsym) begin
               uni_in = '0;
            end
         end
         ST_SRCH: begin
            if (hit) begin
               ent_in = {1'b1, pk_ff};
            end else if (k_ff < count_ff) begin
               pend_in = 1'b1;
               pk_in   = k_ff[ID_W-1:0];
               k_in    = k_ff + 1'b1;
            end else if (count_ff < COUNT_W'(DFA_STATES)) begin
               sr_we    = 1'b1;
               ent_in   = {1'b1, count_ff[ID_W-1:0]};
               count_in = count_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
               ent_in = '0;
            end
         end
         ST_WRITE: begin
            dr_we  = 1'b1;
            s_in   = s_ff + 1'b1;
            q_in   = '0;
            uni_in = '0;
            if (s_ff == SYM_W'(SYMBOLS-1)) begin
               wp_in = wp_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.dfa_count  = count_ff;
               rsp_data_in.overflow   = ovf_ff;
               rsp_data_in.next_state = res_ff.next_state;
               rsp_data_in.has_next   = res_ff.has_next;
               rsp_data_in.is_final   = res_ff.is_final;
               rsp_data_in.subset     = res_ff.subset;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         symcnt_ff    <= 3'd4;
         fmask_ff     <= 8'h00;
         count_ff     <= '0;
         wp_ff        <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NFA_STATES*SYMBOLS; i++) begin
            nfa_ff[i] <= 8'h00;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wp_ff        <= wp_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            if (csr_index == CSR_SYMBOL_COUNT) begin
               symcnt_ff <= csr_wdata[2:0];
            end else begin
               fmask_ff <= csr_wdata;
            end
         end
         if (load_we) begin
            nfa_ff[{req_data.nfa_state, req_data.symbol}] <=
               nfa_ff[{req_data.nfa_state, req_data.symbol}] | req_data.target_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      k_ff        <= k_in;
      pk_ff       <= pk_in;
      q_ff        <= q_in;
      s_ff        <= s_in;
      cur_ff      <= cur_in;
      uni_ff      <= uni_in;
      ent_ff      <= ent_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DFA_STATES))
      else $error("dfa count beyond storage");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == COUNT_W'(DFA_STATES))
      else $error("overflow with free storage");

   a_fetch_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> wp_ff < count_ff)
      else $error("work pointer past stored subsets");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.mode == MODE_RUN |=> state_ff == ST_INIT)
      else $error("run beat did not start construction");

endmodule

// File: design/n2d_ram.sv
// n2d_ram: generic single write, single read ram with registered read data
// depends on nothing
module n2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
